>>> design/tlme_pkg.sv
package tlme_pkg;

  // Default line store capacity in characters.
  localparam int LINE_MAX_DEF = 64;

  // Width of the microprogram counter.
  localparam int PCW = 5;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_GAP    = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR1,
    OP_READ,
    OP_SCAN,
    OP_CLR2,
    OP_EMIT_PEND,
    OP_EMIT_PEND_END,
    OP_EMIT_GAP,
    OP_TRACK,
    OP_SETP,
    OP_EMIT_ERR,
    OP_EMIT_EMPTY,
    OP_FINISH
  } op_t;

  // Jump conditions. A step jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NSTART,
    C_OVF,
    C_IDX_END,
    C_ALL_WS,
    C_BAD,
    C_NO_SYM,
    C_NPEND_HIT,
    C_CUR_SYM,
    C_NGAP_EMIT,
    C_NPEND,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PCW-1:0]   target;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic idle;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic start;
    logic ovf;
    logic idx_end;
    logic all_ws;
    logic bad;
    logic no_sym;
    logic pend_hit;
    logic cur_sym;
    logic gap_emit;
    logic pend_valid;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [4:0] pat;
    logic [2:0] len;
  } code_t;

  // Microprogram step addresses.
  localparam logic [PCW-1:0] S_IDLE      = 5'd0;
  localparam logic [PCW-1:0] S_CHK_OVF   = 5'd1;
  localparam logic [PCW-1:0] S_P1_RD     = 5'd2;
  localparam logic [PCW-1:0] S_P1_SCAN   = 5'd3;
  localparam logic [PCW-1:0] S_P1_END    = 5'd4;
  localparam logic [PCW-1:0] S_CHK_BAD   = 5'd5;
  localparam logic [PCW-1:0] S_P2_INIT   = 5'd6;
  localparam logic [PCW-1:0] S_P2_RD     = 5'd7;
  localparam logic [PCW-1:0] S_P2_EVAL   = 5'd8;
  localparam logic [PCW-1:0] S_P2_PEND   = 5'd9;
  localparam logic [PCW-1:0] S_P2_CUR    = 5'd10;
  localparam logic [PCW-1:0] S_P2_ISGAP  = 5'd11;
  localparam logic [PCW-1:0] S_P2_GAP    = 5'd12;
  localparam logic [PCW-1:0] S_P2_TRACK  = 5'd13;
  localparam logic [PCW-1:0] S_P2_SETP   = 5'd14;
  localparam logic [PCW-1:0] S_P2_END    = 5'd15;
  localparam logic [PCW-1:0] S_P2_LAST   = 5'd16;
  localparam logic [PCW-1:0] S_DONE      = 5'd17;
  localparam logic [PCW-1:0] S_ERR       = 5'd18;
  localparam logic [PCW-1:0] S_ERR_FIN   = 5'd19;
  localparam logic [PCW-1:0] S_EMPTY     = 5'd20;
  localparam logic [PCW-1:0] S_EMPTY_FIN = 5'd21;

  function automatic uword_t uw(op_t op, cond_t cond, logic [PCW-1:0] target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The control program.
  function automatic uword_t ucode(logic [PCW-1:0] pc);
    uword_t w;
    w = uw(OP_NOP, C_ALWAYS, S_IDLE);
    unique case (pc)
      S_IDLE:      w = uw(OP_CLR1,          C_NSTART,    S_IDLE);
      S_CHK_OVF:   w = uw(OP_NOP,           C_OVF,       S_ERR);
      S_P1_RD:     w = uw(OP_READ,          C_IDX_END,   S_P1_END);
      S_P1_SCAN:   w = uw(OP_SCAN,          C_ALWAYS,    S_P1_RD);
      S_P1_END:    w = uw(OP_NOP,           C_ALL_WS,    S_EMPTY);
      S_CHK_BAD:   w = uw(OP_NOP,           C_BAD,       S_ERR);
      S_P2_INIT:   w = uw(OP_CLR2,          C_NO_SYM,    S_EMPTY);
      S_P2_RD:     w = uw(OP_READ,          C_IDX_END,   S_P2_END);
      S_P2_EVAL:   w = uw(OP_NOP,           C_NPEND_HIT, S_P2_CUR);
      S_P2_PEND:   w = uw(OP_EMIT_PEND,     C_OUT_BUSY,  S_P2_PEND);
      S_P2_CUR:    w = uw(OP_NOP,           C_CUR_SYM,   S_P2_SETP);
      S_P2_ISGAP:  w = uw(OP_NOP,           C_NGAP_EMIT, S_P2_TRACK);
      S_P2_GAP:    w = uw(OP_EMIT_GAP,      C_OUT_BUSY,  S_P2_GAP);
      S_P2_TRACK:  w = uw(OP_TRACK,         C_ALWAYS,    S_P2_RD);
      S_P2_SETP:   w = uw(OP_SETP,          C_ALWAYS,    S_P2_RD);
      S_P2_END:    w = uw(OP_NOP,           C_NPEND,     S_DONE);
      S_P2_LAST:   w = uw(OP_EMIT_PEND_END, C_OUT_BUSY,  S_P2_LAST);
      S_DONE:      w = uw(OP_FINISH,        C_ALWAYS,    S_IDLE);
      S_ERR:       w = uw(OP_EMIT_ERR,      C_OUT_BUSY,  S_ERR);
      S_ERR_FIN:   w = uw(OP_FINISH,        C_ALWAYS,    S_IDLE);
      S_EMPTY:     w = uw(OP_EMIT_EMPTY,    C_OUT_BUSY,  S_EMPTY);
      S_EMPTY_FIN: w = uw(OP_FINISH,        C_ALWAYS,    S_IDLE);
      default:     w = uw(OP_NOP,           C_ALWAYS,    S_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Accepted punctuation: ; : - ! ? . ' , and the double quote.
  function automatic logic is_punct(logic [7:0] c);
    return (c == 8'h3B) || (c == 8'h3A) || (c == 8'h2D) || (c == 8'h21) ||
           (c == 8'h3F) || (c == 8'h2E) || (c == 8'h27) || (c == 8'h2C) ||
           (c == 8'h22);
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Morse pattern of a letter (either case) or digit; bit 0 is the first
  // element, a one is a dash.
  function automatic code_t morse_code(logic [7:0] c);
    logic [7:0] f;
    code_t      r;
    f = is_lower(c) ? (c - 8'd32) : c;
    r = '0;
    unique case (f)
      8'h41: r = '{5'b00010, 3'd2}; // A
      8'h42: r = '{5'b00001, 3'd4}; // B
      8'h43: r = '{5'b00101, 3'd4}; // C
      8'h44: r = '{5'b00001, 3'd3}; // D
      8'h45: r = '{5'b00000, 3'd1}; // E
      8'h46: r = '{5'b00100, 3'd4}; // F
      8'h47: r = '{5'b00011, 3'd3}; // G
      8'h48: r = '{5'b00000, 3'd4}; // H
      8'h49: r = '{5'b00000, 3'd2}; // I
      8'h4A: r = '{5'b01110, 3'd4}; // J
      8'h4B: r = '{5'b00101, 3'd3}; // K
      8'h4C: r = '{5'b00010, 3'd4}; // L
      8'h4D: r = '{5'b00011, 3'd2}; // M
      8'h4E: r = '{5'b00001, 3'd2}; // N
      8'h4F: r = '{5'b00111, 3'd3}; // O
      8'h50: r = '{5'b00110, 3'd4}; // P
      8'h51: r = '{5'b01011, 3'd4}; // Q
      8'h52: r = '{5'b00010, 3'd3}; // R
      8'h53: r = '{5'b00000, 3'd3}; // S
      8'h54: r = '{5'b00001, 3'd1}; // T
      8'h55: r = '{5'b00100, 3'd3}; // U
      8'h56: r = '{5'b01000, 3'd4}; // V
      8'h57: r = '{5'b00110, 3'd3}; // W
      8'h58: r = '{5'b01001, 3'd4}; // X
      8'h59: r = '{5'b01101, 3'd4}; // Y
      8'h5A: r = '{5'b00011, 3'd4}; // Z
      8'h30: r = '{5'b11111, 3'd5}; // 0
      8'h31: r = '{5'b11110, 3'd5}; // 1
      8'h32: r = '{5'b11100, 3'd5}; // 2
      8'h33: r = '{5'b11000, 3'd5}; // 3
      8'h34: r = '{5'b10000, 3'd5}; // 4
      8'h35: r = '{5'b00000, 3'd5}; // 5
      8'h36: r = '{5'b00001, 3'd5}; // 6
      8'h37: r = '{5'b00011, 3'd5}; // 7
      8'h38: r = '{5'b00111, 3'd5}; // 8
      8'h39: r = '{5'b01111, 3'd5}; // 9
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/tlme_seq.sv
module tlme_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  tlme_pkg::status_t stat_i,
  output tlme_pkg::ctrl_t   ctrl_o
);

  logic [tlme_pkg::PCW-1:0] pc_r;
  logic [tlme_pkg::PCW-1:0] pc_nxt;
  tlme_pkg::uword_t         word;
  logic                     take;

  assign word = tlme_pkg::ucode(pc_r);

  always_comb begin
    unique case (word.cond)
      tlme_pkg::C_NEVER:     take = 1'b0;
      tlme_pkg::C_ALWAYS:    take = 1'b1;
      tlme_pkg::C_NSTART:    take = !stat_i.start;
      tlme_pkg::C_OVF:       take = stat_i.ovf;
      tlme_pkg::C_IDX_END:   take = stat_i.idx_end;
      tlme_pkg::C_ALL_WS:    take = stat_i.all_ws;
      tlme_pkg::C_BAD:       take = stat_i.bad;
      tlme_pkg::C_NO_SYM:    take = stat_i.no_sym;
      tlme_pkg::C_NPEND_HIT: take = !stat_i.pend_hit;
      tlme_pkg::C_CUR_SYM:   take = stat_i.cur_sym;
      tlme_pkg::C_NGAP_EMIT: take = !stat_i.gap_emit;
      tlme_pkg::C_NPEND:     take = !stat_i.pend_valid;
      tlme_pkg::C_OUT_BUSY:  take = stat_i.out_busy;
      default:               take = 1'b1;
    endcase
    pc_nxt = take ? word.target : (pc_r + tlme_pkg::PCW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tlme_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.idle = (pc_r == tlme_pkg::S_IDLE);

endmodule

>>> design/tlme_dp.sv
module tlme_dp #(
  parameter int LINE_MAX = tlme_pkg::LINE_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlme_pkg::ctrl_t   ctrl_i,
  output tlme_pkg::status_t stat_o,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_character,
  input  logic              in_line_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [4:0]        out_code_pattern,
  output logic [2:0]        out_code_length,
  output logic              out_letter_gap,
  output logic              out_last
);

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LW = $clog2(LINE_MAX + 1);

  logic [7:0]    mem [LINE_MAX];

  logic [LW-1:0] len_r;
  logic          ovf_r;
  logic [LW-1:0] idx_r;
  logic [AW-1:0] pos_r;
  logic [7:0]    rd_r;
  logic          all_ws_r;
  logic          bad_r;
  logic          seen_r;
  logic          prev_ws_r;
  logic [AW-1:0] last_pos_r;
  logic [AW-1:0] prev_pos_r;
  logic          last_gap_r;
  logic          pend_valid_r;
  logic [4:0]    pend_pat_r;
  logic [2:0]    pend_len_r;
  logic [AW-1:0] pend_pos_r;

  logic            out_valid_r;
  tlme_pkg::kind_t kind_r;
  logic [4:0]      pat_r;
  logic [2:0]      clen_r;
  logic            gap_r;
  logic            last_r;

  logic            load;
  logic            room;
  logic            idx_end;
  logic            cur_ws;
  logic            cur_punct;
  logic            cur_sym;
  logic            cur_ok;
  logic            gap_item;
  logic [AW-1:0]   final_pos;
  tlme_pkg::code_t code;
  logic            out_free;
  logic            emit_op;
  logic            emit_now;

  assign load    = in_valid && !in_stall && !in_line_end;
  assign room    = (len_r < LW'(LINE_MAX));
  assign idx_end = (idx_r == len_r);

  assign cur_ws    = tlme_pkg::is_ws(rd_r);
  assign cur_punct = tlme_pkg::is_punct(rd_r);
  assign cur_sym   = tlme_pkg::is_upper(rd_r) || tlme_pkg::is_lower(rd_r) ||
                     tlme_pkg::is_digit(rd_r);
  assign cur_ok    = cur_ws || cur_punct || cur_sym;
  assign gap_item  = cur_ws && !prev_ws_r && seen_r;
  assign final_pos = last_gap_r ? prev_pos_r : last_pos_r;
  assign code      = tlme_pkg::morse_code(rd_r);

  assign out_free = !out_valid_r || !out_stall;
  assign emit_op  = (ctrl_i.op == tlme_pkg::OP_EMIT_PEND) ||
                    (ctrl_i.op == tlme_pkg::OP_EMIT_PEND_END) ||
                    (ctrl_i.op == tlme_pkg::OP_EMIT_GAP) ||
                    (ctrl_i.op == tlme_pkg::OP_EMIT_ERR) ||
                    (ctrl_i.op == tlme_pkg::OP_EMIT_EMPTY);
  assign emit_now = emit_op && out_free;

  assign stat_o.start      = in_valid && !in_stall && in_line_end;
  assign stat_o.ovf        = ovf_r;
  assign stat_o.idx_end    = idx_end;
  assign stat_o.all_ws     = all_ws_r;
  assign stat_o.bad        = bad_r;
  assign stat_o.no_sym     = !seen_r;
  assign stat_o.pend_hit   = pend_valid_r && !cur_punct;
  assign stat_o.cur_sym    = cur_sym;
  assign stat_o.gap_emit   = gap_item && (pos_r <= final_pos);
  assign stat_o.pend_valid = pend_valid_r;
  assign stat_o.out_busy   = !out_free;

  always_ff @(posedge clk) begin
    if (load && room) begin
      mem[len_r[AW-1:0]] <= in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctrl_i.op == tlme_pkg::OP_FINISH) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else if (load) begin
        if (room) begin
          len_r <= len_r + LW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end

      if (ctrl_i.op == tlme_pkg::OP_CLR2) begin
        pend_valid_r <= 1'b0;
      end else if (ctrl_i.op == tlme_pkg::OP_SETP) begin
        pend_valid_r <= 1'b1;
      end else if (out_free && (ctrl_i.op == tlme_pkg::OP_EMIT_PEND ||
                                ctrl_i.op == tlme_pkg::OP_EMIT_PEND_END)) begin
        pend_valid_r <= 1'b0;
      end

      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl_i.op)
      tlme_pkg::OP_CLR1: begin
        idx_r      <= '0;
        all_ws_r   <= 1'b1;
        bad_r      <= 1'b0;
        seen_r     <= 1'b0;
        prev_ws_r  <= 1'b1;
        last_gap_r <= 1'b0;
      end
      tlme_pkg::OP_CLR2: begin
        idx_r     <= '0;
        seen_r    <= 1'b0;
        prev_ws_r <= 1'b1;
      end
      tlme_pkg::OP_READ: begin
        if (!idx_end) begin
          rd_r  <= mem[idx_r[AW-1:0]];
          pos_r <= idx_r[AW-1:0];
          idx_r <= idx_r + LW'(1);
        end
      end
      tlme_pkg::OP_SCAN: begin
        if (!cur_ws) begin
          all_ws_r <= 1'b0;
        end
        if (!cur_ok) begin
          bad_r <= 1'b1;
        end
        if (cur_sym) begin
          prev_pos_r <= last_pos_r;
          last_pos_r <= pos_r;
          last_gap_r <= 1'b0;
          seen_r     <= 1'b1;
        end else if (gap_item) begin
          prev_pos_r <= last_pos_r;
          last_pos_r <= pos_r;
          last_gap_r <= 1'b1;
        end
        prev_ws_r <= cur_ws;
      end
      tlme_pkg::OP_TRACK: begin
        prev_ws_r <= cur_ws;
      end
      tlme_pkg::OP_SETP: begin
        pend_pat_r <= code.pat;
        pend_len_r <= code.len;
        pend_pos_r <= pos_r;
        prev_ws_r  <= 1'b0;
        seen_r     <= 1'b1;
      end
      default: begin
      end
    endcase

    if (emit_now) begin
      unique case (ctrl_i.op)
        tlme_pkg::OP_EMIT_PEND: begin
          kind_r <= tlme_pkg::KIND_SYMBOL;
          pat_r  <= pend_pat_r;
          clen_r <= pend_len_r;
          gap_r  <= !cur_ws;
          last_r <= (pend_pos_r == final_pos);
        end
        tlme_pkg::OP_EMIT_PEND_END: begin
          kind_r <= tlme_pkg::KIND_SYMBOL;
          pat_r  <= pend_pat_r;
          clen_r <= pend_len_r;
          gap_r  <= 1'b0;
          last_r <= (pend_pos_r == final_pos);
        end
        tlme_pkg::OP_EMIT_GAP: begin
          kind_r <= tlme_pkg::KIND_GAP;
          pat_r  <= '0;
          clen_r <= '0;
          gap_r  <= 1'b0;
          last_r <= (pos_r == final_pos);
        end
        tlme_pkg::OP_EMIT_ERR: begin
          kind_r <= tlme_pkg::KIND_ERROR;
          pat_r  <= '0;
          clen_r <= '0;
          gap_r  <= 1'b0;
          last_r <= 1'b1;
        end
        default: begin
          kind_r <= tlme_pkg::KIND_EMPTY;
          pat_r  <= '0;
          clen_r <= '0;
          gap_r  <= 1'b0;
          last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_code_pattern = pat_r;
  assign out_code_length  = clen_r;
  assign out_letter_gap   = gap_r;
  assign out_last         = last_r;

endmodule

>>> design/text_line_morse_encoder.sv
// Loading: one character per cycle while in_stall is low; the line-end
// transaction starts processing. Processing of a line of N stored characters:
// a check pass that reads and scans each character, then an encode pass that
// reads and evaluates each character again, walking the single-port line store.
// Reset (rst_n low, synchronous) idles the sequencer, empties the line and
// drops any result held at the output; the line store itself is not cleared.
module text_line_morse_encoder #(
  parameter int LINE_MAX = tlme_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [4:0] out_code_pattern,
  output logic [2:0] out_code_length,
  output logic       out_letter_gap,
  output logic       out_last
);

  // The sequencer steps through a fixed program held in a read-only table.
  // Each control word selects one datapath operation and a conditional jump.
  // The datapath holds the line store, the scan pointer, the line flags, one
  // pending symbol whose letter gap is still unknown, and the output register.
  tlme_pkg::ctrl_t   ctrl;
  tlme_pkg::status_t stat;

  // Characters are taken only while the program sits at its idle step, so
  // a new line can load while the last result of the previous line still
  // waits in the output register.
  assign in_stall = !ctrl.idle;

  tlme_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // The check pass records whether the line is all whitespace, whether it
  // holds an invalid character, and where its final emitted item sits (a
  // trailing word gap is dropped, so the final item may be an earlier one).
  // The encode pass then emits symbols and word gaps in order, marking the
  // transaction at that final position as the last of the line.
  tlme_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (in_character),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_code_pattern (out_code_pattern),
    .out_code_length  (out_code_length),
    .out_letter_gap   (out_letter_gap),
    .out_last         (out_last)
  );

endmodule
